[sv/rms_pkg.sv]
// Package for the repeat message suppressor: payload structs, request and
// verdict codes, sizing constants and configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps
package rms_pkg;

    localparam int RING_SLOTS_DEF     = 8;
    localparam int CATEGORY_COUNT_DEF = 64;
    localparam int CAT_W              = 6;
    localparam int CFG_IDX_W          = 2;
    localparam int CFG_DATA_W         = 64;
    localparam logic [31:0] MAX32     = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        REQ_CHECK     = 2'd0,
        REQ_RESET_ONE = 2'd1,
        REQ_RESET_ALL = 2'd2,
        REQ_NONE      = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        VERDICT_PASS    = 2'd0,
        VERDICT_BLOCK   = 2'd1,
        VERDICT_SUMMARY = 2'd2,
        VERDICT_RSVD    = 2'd3
    } t_verdict;

    typedef enum logic [1:0] {
        CFG_GLOBAL_ENABLE = 2'd0,
        CFG_CAT_MASK      = 2'd1,
        CFG_WINDOW        = 2'd2,
        CFG_THRESHOLD     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [5:0]  category;
        logic [31:0] msg_hash;
        logic [31:0] now_ticks;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [31:0] dup_count;
        logic [31:0] suppressed_total;
        logic [31:0] summary_total;
    } t_out_item;

    // Front-to-back queue entry: request classified by the front end
    typedef struct packed {
        logic        do_check;
        logic        do_clr_one;
        logic        do_clr_all;
        logic        in_range;
        logic [5:0]  category;
        logic [31:0] msg_hash;
        logic [31:0] now_ticks;
    } t_cmd;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == MAX32) ? v : v + 32'd1;
    endfunction

endpackage

[sv/repeat_message_suppressor_core.sv]
// channel | handshake   | payload
// request | push / full | i_req  (rms_pkg::t_in_item)
// result  | empty / pop | o_res  (rms_pkg::t_out_item)
// config  | i_cfg_we    | i_cfg_idx, i_cfg_data
// Each request passes through the back end as row read, match and write back;
// a category row is read-modified-written only for an enabled, in-range check
// request. Sync active-low reset and reset-all requests clear a per-category
// live flag, so a cleared category reads as an empty ring with zero counters.
// Two-entry queues on both sides let input and output stall independently.
// Depends on rms_pkg, rms_front, rms_back.
`timescale 1ns / 1ps
module repeat_message_suppressor_core #(
    parameter int RING_SLOTS     = rms_pkg::RING_SLOTS_DEF,
    parameter int CATEGORY_COUNT = rms_pkg::CATEGORY_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  rms_pkg::t_in_item                 i_req,
    output logic                              empty,
    input  logic                              pop,
    output rms_pkg::t_out_item                o_res,
    input  logic                              i_cfg_we,
    input  logic [rms_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rms_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    logic        r_global_enable;
    logic [63:0] r_cat_mask;
    logic [31:0] r_window;
    logic [31:0] r_threshold;

    logic          cmd_valid, cmd_take;
    rms_pkg::t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_global_enable <= 1'b0;
            r_cat_mask      <= '1;
            r_window        <= 32'd10000;
            r_threshold     <= 32'd5;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rms_pkg::CFG_GLOBAL_ENABLE: r_global_enable <= i_cfg_data[0];
                rms_pkg::CFG_CAT_MASK:      r_cat_mask      <= i_cfg_data;
                rms_pkg::CFG_WINDOW:        r_window        <= i_cfg_data[31:0];
                rms_pkg::CFG_THRESHOLD:     r_threshold     <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    rms_front #(.CATEGORY_COUNT(CATEGORY_COUNT)) u_front (
        .i_clk, .i_rst_n, .push, .full, .i_item(i_req),
        .i_global_enable(r_global_enable), .i_cat_mask(r_cat_mask),
        .o_cmd_valid(cmd_valid), .i_cmd_take(cmd_take), .o_cmd(cmd)
    );

    rms_back #(.RING_SLOTS(RING_SLOTS), .CATEGORY_COUNT(CATEGORY_COUNT)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .o_cmd_take(cmd_take),
        .i_cmd(cmd), .i_window(r_window), .i_threshold(r_threshold),
        .empty, .pop, .o_item(o_res)
    );

    a_block_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_res.verdict == rms_pkg::VERDICT_BLOCK |-> o_res.dup_count != 32'd0)
        else $error("block result with zero repeat count");
    a_take_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_take |-> cmd_valid)
        else $error("back end took from empty queue");
    a_no_verdict_3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_res.verdict != rms_pkg::VERDICT_RSVD)
        else $error("reserved verdict code");
endmodule

[sv/rms_front.sv]
// Front end: accepts requests, applies enables and range checks, and queues
// classified commands for the back end. Depends on rms_pkg.
`timescale 1ns / 1ps
module rms_front #(
    parameter int CATEGORY_COUNT = rms_pkg::CATEGORY_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  rms_pkg::t_in_item i_item,
    input  logic              i_global_enable,
    input  logic [63:0]       i_cat_mask,
    output logic              o_cmd_valid,
    input  logic              i_cmd_take,
    output rms_pkg::t_cmd     o_cmd
);
    // Two-entry queue
    rms_pkg::t_cmd r_q [2];
    logic          r_rd;
    logic          r_wr;
    logic [1:0]    r_cnt;
    rms_pkg::t_cmd n_cmd;
    logic          do_push, do_pop;

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];
    assign do_push     = push && !full;
    assign do_pop      = i_cmd_take && o_cmd_valid;

    always_comb begin
        n_cmd.in_range     = ({26'd0, i_item.category} < CATEGORY_COUNT);
        n_cmd.category     = i_item.category;
        n_cmd.msg_hash     = i_item.msg_hash;
        n_cmd.now_ticks    = i_item.now_ticks;
        n_cmd.do_check     = (i_item.req_type == rms_pkg::REQ_CHECK) && n_cmd.in_range
                             && i_global_enable && i_cat_mask[i_item.category];
        n_cmd.do_clr_one   = (i_item.req_type == rms_pkg::REQ_RESET_ONE) && n_cmd.in_range;
        n_cmd.do_clr_all   = (i_item.req_type == rms_pkg::REQ_RESET_ALL);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wr <= ~r_wr;
            if (do_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule

[sv/rms_back.sv]
// Back end: reads a category's ring row from memory, matches, updates the
// row and per-category counters, and holds results in an output queue.
// Depends on rms_pkg.
`timescale 1ns / 1ps
module rms_back #(
    parameter int RING_SLOTS     = rms_pkg::RING_SLOTS_DEF,
    parameter int CATEGORY_COUNT = rms_pkg::CATEGORY_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_take,
    input  rms_pkg::t_cmd      i_cmd,
    input  logic [31:0]        i_window,
    input  logic [31:0]        i_threshold,
    output logic               empty,
    input  logic               pop,
    output rms_pkg::t_out_item o_item
);
    localparam int SW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int CW = (CATEGORY_COUNT > 1) ? $clog2(CATEGORY_COUNT) : 1;
    // Per-category meta word: {slot valid bits, head, blocked count, summary count}
    localparam int MW = RING_SLOTS + SW + 64;

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_WRITE} t_state;

    // Ring rows: one memory word per category holding all slots
    logic [RING_SLOTS*96-1:0]    r_mem  [CATEGORY_COUNT];
    logic [RING_SLOTS*96-1:0]    r_row;
    logic [MW-1:0]               r_meta [CATEGORY_COUNT];
    logic [MW-1:0]               r_meta_q;
    // A category whose live flag is clear reads as empty with zero counters
    logic [CATEGORY_COUNT-1:0]   r_live;
    logic                        r_live_q;

    t_state        r_state, n_state;
    rms_pkg::t_cmd r_cmd;

    rms_pkg::t_out_item r_oq [2];
    logic r_ord, r_owr;
    logic [1:0] r_ocnt;

    logic [CW-1:0] cidx;
    logic [RING_SLOTS-1:0] valid_row, new_valid;
    logic [RING_SLOTS-1:0] hit_vec;
    logic hit;
    logic [SW-1:0] hit_s, wr_s, head_cur, head_new;
    logic [31:0] s_hash, s_cnt, s_start, elapsed, inc_cnt;
    logic [RING_SLOTS*96-1:0] new_row;
    logic [MW-1:0] new_meta;
    logic [31:0] blk_cur, sum_cur, blk_new, sum_new, rc;
    logic [1:0] verdict;
    logic wr_row, oq_push, oq_pop;
    rms_pkg::t_out_item res;

    assign cidx = r_cmd.category[CW-1:0];
    assign empty = (r_ocnt == 2'd0);
    assign o_item = r_oq[r_ord];
    assign oq_pop = pop && !empty;

    always_comb begin
        n_state    = r_state;
        o_cmd_take = 1'b0;
        oq_push    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && r_ocnt != 2'd2) begin
                    o_cmd_take = 1'b1;
                    n_state    = ST_READ;
                end
            end
            ST_READ:  n_state = ST_WRITE;
            ST_WRITE: begin
                oq_push = 1'b1;
                n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Match over the registered row, lowest slot first
    always_comb begin
        valid_row = r_live_q ? r_meta_q[MW-1 -: RING_SLOTS] : '0;
        head_cur  = r_live_q ? r_meta_q[64 +: SW] : '0;
        blk_cur   = r_live_q ? r_meta_q[32 +: 32] : '0;
        sum_cur   = r_live_q ? r_meta_q[31:0] : '0;
        hit = 1'b0;
        hit_s = '0;
        for (int s = RING_SLOTS - 1; s >= 0; s--) begin
            hit_vec[s] = valid_row[s] && (r_row[s*96+64 +: 32] == r_cmd.msg_hash);
            if (hit_vec[s]) begin
                hit = 1'b1;
                hit_s = SW'(s);
            end
        end
        s_hash  = r_row[hit_s*96+64 +: 32];
        s_cnt   = r_row[hit_s*96+32 +: 32];
        s_start = r_row[hit_s*96 +: 32];
        elapsed = r_cmd.now_ticks - s_start;
        inc_cnt = rms_pkg::sat_inc(s_cnt);
        blk_new = blk_cur;
        sum_new = sum_cur;
        rc      = '0;
        verdict = rms_pkg::VERDICT_PASS;
        new_row = r_row;
        new_valid = valid_row;
        head_new  = head_cur;
        wr_s    = hit ? hit_s : head_cur;
        wr_row  = r_cmd.do_check;
        if (!hit) begin
            new_row[wr_s*96 +: 96] = {r_cmd.msg_hash, 32'd1, r_cmd.now_ticks};
            new_valid[wr_s] = 1'b1;
            head_new = (32'(wr_s) == RING_SLOTS - 1) ? '0 : wr_s + 1'b1;
        end else if (elapsed > i_window) begin
            if (s_cnt >= i_threshold) begin
                rc      = rms_pkg::sat_inc(s_cnt - i_threshold);
                sum_new = rms_pkg::sat_inc(sum_cur);
                verdict = rms_pkg::VERDICT_SUMMARY;
            end
            new_row[wr_s*96 +: 96] = {s_hash, 32'd1, r_cmd.now_ticks};
        end else begin
            new_row[wr_s*96 +: 96] = {s_hash, inc_cnt, s_start};
            if (inc_cnt > i_threshold) begin
                rc      = inc_cnt - i_threshold;
                blk_new = rms_pkg::sat_inc(blk_cur);
                verdict = rms_pkg::VERDICT_BLOCK;
            end
        end
        new_meta = {new_valid, head_new, blk_new, sum_new};
        if (!r_cmd.do_check) begin
            verdict = rms_pkg::VERDICT_PASS;
            rc      = '0;
        end
        res.verdict          = verdict;
        res.dup_count        = rc;
        res.suppressed_total = '0;
        res.summary_total    = '0;
        if (r_cmd.in_range) begin
            if (r_cmd.do_check) begin
                res.suppressed_total = blk_new;
                res.summary_total    = sum_new;
            end else if (!(r_cmd.do_clr_one || r_cmd.do_clr_all)) begin
                res.suppressed_total = blk_cur;
                res.summary_total    = sum_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd <= i_cmd;
        end
        if (r_state == ST_IDLE) begin
            r_row    <= r_mem[i_cmd.category[CW-1:0]];
            r_meta_q <= r_meta[i_cmd.category[CW-1:0]];
            r_live_q <= r_live[i_cmd.category[CW-1:0]];
        end
        if (r_state == ST_WRITE && wr_row) begin
            r_mem[cidx]  <= new_row;
            r_meta[cidx] <= new_meta;
        end
        if (oq_push) begin
            r_oq[r_owr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ord   <= 1'b0;
            r_owr   <= 1'b0;
            r_ocnt  <= 2'd0;
            r_live  <= '0;
        end else begin
            r_state <= n_state;
            if (oq_push) r_owr <= ~r_owr;
            if (oq_pop)  r_ord <= ~r_ord;
            r_ocnt <= r_ocnt + {1'b0, oq_push} - {1'b0, oq_pop};
            if (r_state == ST_WRITE) begin
                if (r_cmd.do_clr_all) begin
                    r_live <= '0;
                end else if (r_cmd.do_clr_one) begin
                    r_live[cidx] <= 1'b0;
                end else if (r_cmd.do_check) begin
                    r_live[cidx] <= 1'b1;
                end
            end
        end
    end
endmodule
